FILE: rtl/signed_radix_digit_converter_assert.svh
// Assertion macros used by the converter top level.
`ifndef SIGNED_RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define SIGNED_RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srdc_pkg.sv
// Package with shared types, constants and helper functions of the converter.
`default_nettype none
package srdc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX      = 16;
  localparam int DIGIT_W        = 4;
  localparam int RADIX_W        = 5;
  localparam int CHAR_W         = 8;
  localparam int STACK_DEPTH    = 32;
  localparam int COUNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Control of the digit stack: push shifts toward the deep end, pop toward the top.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic logic [CHAR_W-1:0] alpha_char(
    input logic [CFG_DATA_W-1:0] chars_low,
    input logic [CFG_DATA_W-1:0] chars_high,
    input logic [DIGIT_W-1:0]    digit
  );
    logic [2*CFG_DATA_W-1:0] all_chars;
    all_chars = {chars_high, chars_low};
    return all_chars[digit*CHAR_W +: CHAR_W];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/srdc_digit_cell.sv
// One cell of the digit stack chain.
`default_nettype none
module srdc_digit_cell (
  input  wire                              clk,
  input  wire  srdc_pkg::stk_ctl_t         ctl,
  input  wire  [srdc_pkg::DIGIT_W-1:0]     below_digit,
  input  wire  [srdc_pkg::DIGIT_W-1:0]     above_digit,
  output logic [srdc_pkg::DIGIT_W-1:0]     digit
);

  logic [srdc_pkg::DIGIT_W-1:0] digit_r;
  logic [srdc_pkg::DIGIT_W-1:0] digit_nxt;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.push) begin
      digit_nxt = below_digit;
    end else if (ctl.pop) begin
      digit_nxt = above_digit;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule
`default_nettype wire

FILE: rtl/srdc_divider.sv
// Iterative restoring divider by the radix, one quotient bit per cycle.
`default_nettype none
module srdc_divider #(
  parameter int VALUE_BITS = srdc_pkg::VALUE_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [VALUE_BITS-1:0]            dividend,
  input  wire  [srdc_pkg::RADIX_W-1:0]     radix,
  output logic                             done,
  output logic [VALUE_BITS-1:0]            quotient,
  output logic [srdc_pkg::DIGIT_W-1:0]     remainder
);

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]        q_r, q_nxt;
  logic [srdc_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [srdc_pkg::RADIX_W-1:0] trial;
  logic                         fits;

  // The partial remainder stays below the radix, so it fits a digit.
  always_comb begin
    trial    = {rem_r, q_r[VALUE_BITS-1]};
    fits     = (trial >= radix);
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = {q_r[VALUE_BITS-2:0], fits};
      rem_nxt  = fits ? srdc_pkg::DIGIT_W'(trial - radix)
                      : srdc_pkg::DIGIT_W'(trial);
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: rtl/signed_radix_digit_converter.sv
// Top level: signed integer to character string in a configured radix.
//
// Usage: write radix (index 0) and the two alphabet words (indexes 1 and 2)
// on the cfg_ channel while the block is idle; cfg_ready is always high.
// A number is transferred on the in_ channel when in_valid is high and
// in_stall is low. Its characters leave on the out_ channel, most significant
// digit first, led by '-' for a negative number, with out_last_char on the
// final one. An invalid alphabet yields one transfer with out_bad_alphabet
// and out_last_char set.
// Each digit comes from a pass of the bit-serial radix divider, which
// produces all digits before the first character leaves; the characters
// then follow back to back while the sink takes them; radix 2 at 32 bits,
// with the most digits, is the worst case.
// Digits wait in a chain of stack cells that shifts one place per push or pop.
// in_stall stays high from the transfer of a number until its last character
// is loaded into the output register; a stalled sink holds that register.
// Reset clears the control state and the configuration registers.
`default_nettype none
`include "signed_radix_digit_converter_assert.svh"
module signed_radix_digit_converter #(
  parameter int VALUE_BITS = srdc_pkg::VALUE_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [srdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [srdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [VALUE_BITS-1:0]        in_number,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [srdc_pkg::CHAR_W-1:0]         out_char,
  output logic                                out_bad_alphabet,
  output logic                                out_last_char
);

  localparam int DW = srdc_pkg::DIGIT_W;
  localparam int SD = srdc_pkg::STACK_DEPTH;
  localparam int CW = srdc_pkg::COUNT_W;

  // Configuration registers.
  logic [srdc_pkg::RADIX_W-1:0]    radix_r;
  logic [srdc_pkg::CFG_DATA_W-1:0] chars_low_r;
  logic [srdc_pkg::CFG_DATA_W-1:0] chars_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= '0;
      chars_low_r  <= '0;
      chars_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srdc_pkg::CFG_RADIX:      radix_r      <= cfg_data[srdc_pkg::RADIX_W-1:0];
        srdc_pkg::CFG_CHARS_LOW:  chars_low_r  <= cfg_data;
        srdc_pkg::CFG_CHARS_HIGH: chars_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Radix range and alphabet check over the characters in use.
  logic alpha_ok;
  always_comb begin
    logic [srdc_pkg::CHAR_W-1:0] ci;
    alpha_ok = (radix_r >= srdc_pkg::RADIX_W'(2)) &&
               (radix_r <= srdc_pkg::RADIX_W'(srdc_pkg::MAX_RADIX));
    for (int i = 0; i < 16; i++) begin
      ci = srdc_pkg::alpha_char(chars_low_r, chars_high_r, DW'(i));
      if ((srdc_pkg::RADIX_W'(i) < radix_r) &&
          (ci == srdc_pkg::CHAR_PLUS || ci == srdc_pkg::CHAR_MINUS)) begin
        alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < 16; j++) begin
        if ((srdc_pkg::RADIX_W'(j) < radix_r) &&
            (ci == srdc_pkg::alpha_char(chars_low_r, chars_high_r, DW'(j)))) begin
          alpha_ok = 1'b0;
        end
      end
    end
  end

  // Divider.
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [DW-1:0]         div_remainder;

  srdc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (radix_r),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Digit stack as a chain of cells; cell 0 is the top.
  srdc_pkg::stk_ctl_t stk_ctl;
  logic [DW-1:0]      cell_digit [SD];

  for (genvar g = 0; g < SD; g++) begin : g_cell
    logic [DW-1:0] below_d;
    logic [DW-1:0] above_d;
    if (g == 0) begin : g_top
      assign below_d = div_remainder;
    end else begin : g_mid
      assign below_d = cell_digit[g-1];
    end
    if (g == SD - 1) begin : g_deep
      assign above_d = '0;
    end else begin : g_rest
      assign above_d = cell_digit[g+1];
    end
    srdc_digit_cell u_cell (
      .clk         (clk),
      .ctl         (stk_ctl),
      .below_digit (below_d),
      .above_digit (above_d),
      .digit       (cell_digit[g])
    );
  end

  // Control.
  srdc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [srdc_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic             out_bad_r, out_bad_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_free;
  logic             in_xfer;
  logic [CW-1:0]    count_inc;
  logic [VALUE_BITS-1:0] magnitude;

  assign in_stall  = (state_r != srdc_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign count_inc = count_r + CW'(1);
  // Unsigned negation keeps the most negative value exact.
  assign magnitude = in_number[VALUE_BITS-1] ? (~in_number + VALUE_BITS'(1))
                                             : in_number;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    div_dividend  = magnitude;
    stk_ctl       = '0;
    unique case (state_r)
      srdc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (alpha_ok) begin
            neg_nxt   = in_number[VALUE_BITS-1];
            count_nxt = '0;
            div_start = 1'b1;
            state_nxt = srdc_pkg::ST_DIV;
          end else begin
            state_nxt = srdc_pkg::ST_ERR;
          end
        end
      end
      srdc_pkg::ST_DIV: begin
        if (div_done) begin
          stk_ctl.push = 1'b1;
          count_nxt    = count_inc;
          if (div_quotient != '0 && count_inc != CW'(SD)) begin
            div_start    = 1'b1;
            div_dividend = div_quotient;
          end else begin
            state_nxt = neg_r ? srdc_pkg::ST_SIGN : srdc_pkg::ST_EMIT;
          end
        end
      end
      srdc_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srdc_pkg::CHAR_MINUS;
          out_bad_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = srdc_pkg::ST_EMIT;
        end
      end
      srdc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = srdc_pkg::alpha_char(chars_low_r, chars_high_r, cell_digit[0]);
          out_bad_nxt   = 1'b0;
          out_last_nxt  = (count_r == CW'(1));
          stk_ctl.pop   = 1'b1;
          count_nxt     = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = srdc_pkg::ST_IDLE;
          end
        end
      end
      srdc_pkg::ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_bad_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = srdc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srdc_pkg::ST_IDLE;
      count_r     <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_bad_alphabet = out_bad_r;
  assign out_last_char    = out_last_r;

  `SRDC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_xfer, in_stall, "block took a number but is not busy")
  `SRDC_ASSERT_NOW(a_emit_has_digit, clk, rst_n, state_r == srdc_pkg::ST_EMIT, count_r != '0, "emitting with an empty digit stack")
  `SRDC_ASSERT_NOW(a_error_is_last, clk, rst_n, out_valid_r && out_bad_r, out_last_r, "error result is not marked last")

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the signed radix digit converter.
`timescale 1ns / 1ps
module tb;

  localparam logic [srdc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 8000;
  localparam int TAIL_CYCLES = 1200;

  // Decimal and hexadecimal alphabets, digit 0 in the low byte.
  localparam logic [63:0] DIGITS_LOW  = 64'h3736353433323130;
  localparam logic [63:0] DEC_HIGH    = 64'h0000000000003938;
  localparam logic [63:0] HEX_HIGH    = 64'h6665646362613938;

  typedef struct packed {
    logic [srdc_pkg::CHAR_W-1:0] ch;
    logic                        bad;
    logic                        last;
  } glyph_t;

  class char_scoreboard;
    bit [srdc_pkg::RADIX_W-1:0] radix;
    bit [63:0]                  chars_lo;
    bit [63:0]                  chars_hi;
    glyph_t                     expected_chars[$];
    int                         failures;

    function void set_reg(logic [srdc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        srdc_pkg::CFG_RADIX:      radix = data[srdc_pkg::RADIX_W-1:0];
        srdc_pkg::CFG_CHARS_LOW:  chars_lo = data;
        srdc_pkg::CFG_CHARS_HIGH: chars_hi = data;
        default: ;
      endcase
    endfunction

    function bit [7:0] glyph_of(bit [3:0] d);
      if (d < 8) return chars_lo[8 * int'(d) +: 8];
      return chars_hi[8 * (int'(d) - 8) +: 8];
    endfunction

    function bit alphabet_ok();
      if (radix < 2 || radix > srdc_pkg::MAX_RADIX) return 1'b0;
      for (int i = 0; i < radix; i++) begin
        if (glyph_of(4'(i)) == srdc_pkg::CHAR_PLUS || glyph_of(4'(i)) == srdc_pkg::CHAR_MINUS)
          return 1'b0;
        for (int j = i + 1; j < radix; j++)
          if (glyph_of(4'(i)) == glyph_of(4'(j))) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void predict_chars(logic [31:0] num);
      bit [31:0] mag;
      bit [3:0]  digits[$];
      glyph_t    g;
      if (!alphabet_ok()) begin
        g.ch = '0;
        g.bad = 1'b1;
        g.last = 1'b1;
        expected_chars.push_back(g);
        return;
      end
      // Two's complement negation keeps the most negative value in range as unsigned.
      mag = num;
      if (num[31]) mag = ~num + 32'd1;
      do begin
        digits.push_front(4'(mag % radix));
        mag = mag / radix;
      end while (mag != 0 && digits.size() < srdc_pkg::STACK_DEPTH);
      g.bad = 1'b0;
      if (num[31]) begin
        g.ch = srdc_pkg::CHAR_MINUS;
        g.last = 1'b0;
        expected_chars.push_back(g);
      end
      foreach (digits[i]) begin
        g.ch = glyph_of(digits[i]);
        g.last = (i == digits.size() - 1);
        expected_chars.push_back(g);
      end
    endfunction

    function void flag(string what, glyph_t want, glyph_t got);
      failures++;
      if (failures <= 10)
        $display("%s: expected char %h bad %b last %b, got char %h bad %b last %b",
                 what, want.ch, want.bad, want.last, got.ch, got.bad, got.last);
    endfunction

    function void check_char(glyph_t got);
      glyph_t want;
      if (expected_chars.size() == 0) begin
        flag("unexpected transfer", '0, got);
        return;
      end
      want = expected_chars.pop_front();
      // The character of a bad-alphabet transfer carries no meaning.
      if (want.bad) got.ch = want.ch;
      if (got !== want) flag("char mismatch", want, got);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function int close_out();
      while (expected_chars.size() != 0) flag("missing transfer", expected_chars.pop_front(), '0);
      return failures;
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [srdc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [srdc_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [31:0]                in_number = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [srdc_pkg::CHAR_W-1:0]       out_char;
  logic                              out_bad_alphabet;
  logic                              out_last_char;

  char_scoreboard sb = new();
  logic [31:0]    number_q[$];
  int             idle_cycles = 0;
  logic [5:0]     stall_tick = '0;
  logic [7:0]     stall_mask = '0;

  signed_radix_digit_converter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_bad_alphabet (out_bad_alphabet),
    .out_last_char    (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && !in_stall) sb.predict_chars(in_number);
    if (rst_n && out_valid && !out_stall)
      sb.check_char({out_char, out_bad_alphabet, out_last_char});
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // The sink reloads an eight-bit stall pattern whenever its tick counter wraps;
  // bit 0 is never set, so no stall runs past the end of a pass over the pattern.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == 6'd0) begin
      case ($urandom_range(0, 3))
        0: stall_mask <= 8'h00;
        1: stall_mask <= 8'($urandom) & 8'hFE;
        2: stall_mask <= 8'hAA;
        default: stall_mask <= 8'hFE;
      endcase
    end
    out_stall <= stall_mask[stall_tick[2:0]];
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(input logic [srdc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_alphabet(input bit [4:0] r, input bit [63:0] lo, input bit [63:0] hi);
    bit [63:0] radix_word;
    radix_word = {$urandom, $urandom};
    radix_word[4:0] = r;
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(srdc_pkg::CFG_RADIX, radix_word);
    write_reg(srdc_pkg::CFG_CHARS_LOW, lo);
    write_reg(srdc_pkg::CFG_CHARS_HIGH, hi);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_number(input logic [31:0] num);
    in_valid  <= 1'b1;
    in_number <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the queued numbers in bursts; at hold_at the sender waits for the
  // converter to drain before it goes on.
  task automatic feed_numbers(input int hold_at);
    int burst_left;
    int total;
    total = number_q.size();
    burst_left = $urandom_range(1, 16);
    for (int idx = 0; idx < total; idx++) begin
      if (idx == hold_at) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      send_number(number_q[idx]);
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    number_q.delete();
  endtask

  function automatic void make_alphabet(input int r, output bit [63:0] lo, output bit [63:0] hi);
    bit [127:0] all;
    bit [7:0]   c;
    bit         used[256];
    foreach (used[k]) used[k] = 1'b0;
    all = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < r; i++) begin
      do c = 8'($urandom_range(0, 255));
      while (c == srdc_pkg::CHAR_PLUS || c == srdc_pkg::CHAR_MINUS || used[c]);
      used[c] = 1'b1;
      all[i * 8 +: 8] = c;
    end
    lo = all[63:0];
    hi = all[127:64];
  endfunction

  function automatic void make_bad_alphabet(output bit [4:0] r, output bit [63:0] lo,
                                            output bit [63:0] hi);
    bit [127:0] all;
    int         p;
    int         q;
    case ($urandom_range(0, 3))
      0: begin
        r = 5'($urandom_range(0, 1));
        make_alphabet(16, lo, hi);
      end
      1: begin
        r = 5'($urandom_range(17, 31));
        make_alphabet(16, lo, hi);
      end
      2: begin
        r = 5'($urandom_range(2, 16));
        make_alphabet(int'(r), lo, hi);
        all = {hi, lo};
        p = $urandom_range(0, r - 1);
        all[p * 8 +: 8] = $urandom_range(0, 1) ? srdc_pkg::CHAR_PLUS : srdc_pkg::CHAR_MINUS;
        lo = all[63:0];
        hi = all[127:64];
      end
      default: begin
        r = 5'($urandom_range(2, 16));
        make_alphabet(int'(r), lo, hi);
        all = {hi, lo};
        p = $urandom_range(0, r - 2);
        q = $urandom_range(p + 1, r - 1);
        all[q * 8 +: 8] = all[p * 8 +: 8];
        lo = all[63:0];
        hi = all[127:64];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_number(input int r);
    int          span;
    logic [31:0] v;
    span = r * r * r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5: return $urandom_range(0, span);
      6, 7: return 32'd0 - $urandom_range(1, span);
      8: begin
        case ($urandom_range(0, 4))
          0: return 32'h00000000;
          1: return 32'hFFFFFFFF;
          2: return 32'h00000001;
          3: return 32'h80000000;
          default: return 32'h7FFFFFFF;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? 32'd0 - v : v;
      end
    endcase
  endfunction

  initial begin
    bit [63:0] lo;
    bit [63:0] hi;
    bit [4:0]  r;
    int        count;
    int        failures;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still hold their reset values, so the alphabet is empty.
    number_q.push_back(32'd5);
    feed_numbers(-1);

    set_alphabet(5'd10, DIGITS_LOW, DEC_HIGH);
    number_q.push_back(32'd0);
    number_q.push_back(32'd1);
    number_q.push_back(32'hFFFFFFFF);
    number_q.push_back(32'h7FFFFFFF);
    number_q.push_back(32'h80000000);
    number_q.push_back(-32'sd10);
    number_q.push_back(32'd1000000000);
    feed_numbers(-1);

    set_alphabet(5'd16, DIGITS_LOW, HEX_HIGH);
    number_q.push_back(32'h80000000);
    number_q.push_back(32'hFFFFFFFF);
    number_q.push_back(32'h7FFFFFFF);
    feed_numbers(-1);

    // Signs sit beyond the two digits in use and must not matter.
    set_alphabet(5'd2, 64'h2B2B2B2B2B2D3130, 64'h2B2B2B2B2B2B2B2B);
    number_q.push_back(32'h80000000);
    number_q.push_back(32'h7FFFFFFF);
    number_q.push_back(32'd0);
    feed_numbers(-1);

    // A zero byte is an ordinary digit character.
    set_alphabet(5'd3, 64'h0000000000625F00, 64'h0);
    number_q.push_back(32'd9);
    number_q.push_back(-32'sd8);
    feed_numbers(-1);

    set_alphabet(5'd1, DIGITS_LOW, DEC_HIGH);
    number_q.push_back(32'd7);
    feed_numbers(-1);
    set_alphabet(5'd17, DIGITS_LOW, HEX_HIGH);
    number_q.push_back(-32'sd3);
    feed_numbers(-1);
    set_alphabet(5'd31, DIGITS_LOW, HEX_HIGH);
    number_q.push_back(32'd12345);
    feed_numbers(-1);
    set_alphabet(5'd16, 64'h37362B3433323130, HEX_HIGH);
    number_q.push_back(32'd42);
    feed_numbers(-1);
    set_alphabet(5'd16, DIGITS_LOW, 64'h3065646362613938);
    number_q.push_back(32'h80000000);
    feed_numbers(-1);
    set_alphabet(5'd16, DIGITS_LOW, 64'h2D65646362613938);
    number_q.push_back(32'd0);
    feed_numbers(-1);

    for (int p = 0; p < 8; p++) begin
      if (p == 3 || p == 6) begin
        make_bad_alphabet(r, lo, hi);
        count = 6;
      end else begin
        r = (p == 0) ? 5'd2 : (p == 1) ? 5'd16 : 5'($urandom_range(2, 16));
        make_alphabet(int'(r), lo, hi);
        count = 25;
      end
      set_alphabet(r, lo, hi);
      repeat (count) number_q.push_back(pick_number((r >= 2 && r <= 16) ? int'(r) : 10));
      feed_numbers(count / 2);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    failures = sb.close_out();
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/srdc_pkg.sv
rtl/srdc_digit_cell.sv
rtl/srdc_divider.sv
rtl/signed_radix_digit_converter.sv
tb/tb.sv
